>>> sv/local_global_branch_predictor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the local/global branch predictor
// Same-cycle and next-cycle implication checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LOCAL_GLOBAL_BRANCH_PREDICTOR_ASSERT_SVH
`define LOCAL_GLOBAL_BRANCH_PREDICTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define LGBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lgbp: same-cycle check failed");

`define LGBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lgbp: next-cycle check failed");

`else

`define LGBP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LGBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/lgbp_pkg.sv
// ----------------------------------------------------------------------------
// lgbp_pkg
// Shared types and defaults for the local/global branch predictor.
// ----------------------------------------------------------------------------
package lgbp_pkg;

	localparam int LOCAL_HIST_BITS_DEF  = 14;
	localparam int GLOBAL_HIST_BITS_DEF = 14;
	localparam int LOCAL_INDEX_BITS_DEF = 10;
	localparam int CTR_BITS_DEF         = 2;

	localparam int IP_W = 48;

	localparam logic CMD_PREDICT = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	typedef struct packed {
		logic            command;
		logic [IP_W-1:0] ip;
		logic            taken;
	} in_t;

	typedef struct packed {
		logic predict_taken;
		logic used_local;
	} out_t;

endpackage

>>> sv/lgbp_ram.sv
// ----------------------------------------------------------------------------
// lgbp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// Read during write to the same address returns the old contents.
// ----------------------------------------------------------------------------
module lgbp_ram #(
	parameter int ADDR_BITS = 10,
	parameter int WIDTH     = 14
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/local_global_branch_predictor.sv
// ----------------------------------------------------------------------------
// local_global_branch_predictor
// A predict word passes through ST_S1 and ST_S2 and is registered into out_data_q when it commits.
// A new word is accepted only in ST_IDLE, or in ST_S2 once the current word is done; the
// dependent history-table read followed by the local counter-table read sets the pace.
// Reset: tables swept to zero, clr_q stepping over 2^max(table index widths) addresses, in_ready low.
// ----------------------------------------------------------------------------
`include "local_global_branch_predictor_assert.svh"

module local_global_branch_predictor #(
	parameter int LOCAL_HIST_BITS  = lgbp_pkg::LOCAL_HIST_BITS_DEF,
	parameter int GLOBAL_HIST_BITS = lgbp_pkg::GLOBAL_HIST_BITS_DEF,
	parameter int LOCAL_INDEX_BITS = lgbp_pkg::LOCAL_INDEX_BITS_DEF,
	parameter int CTR_BITS         = lgbp_pkg::CTR_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lgbp_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lgbp_pkg::out_t out_data
);

	import lgbp_pkg::*;

	localparam int LHB = LOCAL_HIST_BITS;
	localparam int GHB = GLOBAL_HIST_BITS;
	localparam int LIB = LOCAL_INDEX_BITS;
	localparam int HMAX = (LHB > GHB) ? LHB : GHB;
	localparam int CLR_BITS = (HMAX > LIB) ? HMAX : LIB;

	typedef enum logic [3:0] {
		ST_CLR  = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_S1   = 4'b0100,
		ST_S2   = 4'b1000
	} state_t;

	state_t state_q, state_nx;

	logic [CLR_BITS-1:0] clr_q;
	logic [GHB-1:0]      ghist_q;
	logic                choose_q;
	logic                lastp_q;
	logic                out_valid_q;
	out_t                out_data_q;

	// per-item registers
	logic                cmd_s1;
	logic                taken_s1;
	logic [LIB-1:0]      li_s1;
	logic [GHB-1:0]      gi_s1;
	logic                fwd_h_s1;
	logic [LHB-1:0]      fwd_hdata_s1;
	logic                fwd_g_s1;
	logic [CTR_BITS-1:0] fwd_gdata_s1;
	logic [LHB-1:0]      lh_s2;

	logic                accept;
	logic                in_clr;
	logic                done;
	logic                commit_upd;
	logic                commit_pred;
	logic [GHB-1:0]      ghist_nx;
	logic [GHB-1:0]      ghist_cur;
	logic [IP_W-1:0]     hash;
	logic [LIB-1:0]      li_in;
	logic [GHB-1:0]      gi_in;
	logic [LHB-1:0]      hist_new;
	logic [LHB-1:0]      lh_cur;
	logic [CTR_BITS-1:0] lctr_cur;
	logic [CTR_BITS-1:0] gctr_cur;
	logic [CTR_BITS-1:0] lctr_new;
	logic [CTR_BITS-1:0] gctr_new;
	logic                pred;

	logic [LHB-1:0]      hist_rdata;
	logic [CTR_BITS-1:0] lctr_rdata;
	logic [CTR_BITS-1:0] gctr_rdata;

	logic                hist_we, lctr_we, gctr_we;
	logic [LIB-1:0]      hist_waddr;
	logic [LHB-1:0]      lctr_waddr;
	logic [GHB-1:0]      gctr_waddr;
	logic [LHB-1:0]      hist_wdata;
	logic [CTR_BITS-1:0] lctr_wdata;
	logic [CTR_BITS-1:0] gctr_wdata;

	function automatic logic [CTR_BITS-1:0] ctr_step(input logic [CTR_BITS-1:0] c,
			input logic up);
		logic [CTR_BITS-1:0] r;
		r = c;
		if (up) begin
			if (c != {CTR_BITS{1'b1}}) r = c + 1'b1;
		end else begin
			if (c != '0) r = c - 1'b1;
		end
		return r;
	endfunction

	// ---------------- control ----------------
	assign in_clr      = (state_q == ST_CLR);
	assign done        = (cmd_s1 == CMD_UPDATE) || !out_valid_q || out_ready;
	assign commit_upd  = (state_q == ST_S2) && (cmd_s1 == CMD_UPDATE);
	assign commit_pred = (state_q == ST_S2) && (cmd_s1 == CMD_PREDICT) && done;
	assign in_ready    = (state_q == ST_IDLE) || ((state_q == ST_S2) && done);
	assign accept      = in_valid && in_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLR:  if (&clr_q) state_nx = ST_IDLE;
			ST_IDLE: if (accept) state_nx = ST_S1;
			ST_S1:   state_nx = ST_S2;
			ST_S2: begin
				if (done) state_nx = accept ? ST_S1 : ST_IDLE;
			end
			default: state_nx = ST_CLR;
		endcase
	end

	// ---------------- front: hashes, forwarding ----------------
	assign ghist_nx  = {ghist_q[GHB-2:0], taken_s1};
	assign ghist_cur = commit_upd ? ghist_nx : ghist_q;
	assign hash      = {{(IP_W-GHB){1'b0}}, ghist_cur} ^ in_data.ip
	                   ^ (in_data.ip >> GHB) ^ (in_data.ip >> (2 * GHB));
	assign gi_in     = hash[GHB-1:0];
	assign li_in     = in_data.ip[LIB-1:0];

	// stage 1: history arrives, select local counter
	assign lh_cur = fwd_h_s1 ? fwd_hdata_s1 : hist_rdata;

	// stage 2: both counters available
	assign lctr_cur = lctr_rdata;
	assign gctr_cur = fwd_g_s1 ? fwd_gdata_s1 : gctr_rdata;
	assign pred     = choose_q ? (lctr_cur != '0) : (gctr_cur != '0);
	assign lctr_new = ctr_step(lctr_cur, taken_s1);
	assign gctr_new = ctr_step(gctr_cur, taken_s1);
	assign hist_new = {lh_s2[LHB-2:0], taken_s1};

	// write ports: clearing sweep or update commit
	always_comb begin
		if (in_clr) begin
			hist_we    = 1'b1;
			lctr_we    = 1'b1;
			gctr_we    = 1'b1;
			hist_waddr = clr_q[LIB-1:0];
			lctr_waddr = clr_q[LHB-1:0];
			gctr_waddr = clr_q[GHB-1:0];
			hist_wdata = '0;
			lctr_wdata = '0;
			gctr_wdata = '0;
		end else begin
			hist_we    = commit_upd;
			lctr_we    = commit_upd;
			gctr_we    = commit_upd;
			hist_waddr = li_s1;
			lctr_waddr = lh_s2;
			gctr_waddr = gi_s1;
			hist_wdata = hist_new;
			lctr_wdata = lctr_new;
			gctr_wdata = gctr_new;
		end
	end

	lgbp_ram #(.ADDR_BITS(LIB), .WIDTH(LHB)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (accept),
		.raddr (li_in),
		.rdata (hist_rdata)
	);

	lgbp_ram #(.ADDR_BITS(LHB), .WIDTH(CTR_BITS)) u_lctr (
		.clk   (clk),
		.we    (lctr_we),
		.waddr (lctr_waddr),
		.wdata (lctr_wdata),
		.re    (state_q == ST_S1),
		.raddr (lh_cur),
		.rdata (lctr_rdata)
	);

	lgbp_ram #(.ADDR_BITS(GHB), .WIDTH(CTR_BITS)) u_gctr (
		.clk   (clk),
		.we    (gctr_we),
		.waddr (gctr_waddr),
		.wdata (gctr_wdata),
		.re    (accept),
		.raddr (gi_in),
		.rdata (gctr_rdata)
	);

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			ghist_q     <= '0;
			choose_q    <= 1'b0;
			lastp_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (in_clr) clr_q <= clr_q + 1'b1;
			if (commit_upd) begin
				ghist_q <= ghist_nx;
				if (lastp_q != taken_s1) choose_q <= ~choose_q;
			end
			if (commit_pred) begin
				lastp_q     <= pred;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= in_data.command;
			taken_s1     <= in_data.taken;
			li_s1        <= li_in;
			gi_s1        <= gi_in;
			// same-entry read while the prior update writes: take the new value
			fwd_h_s1     <= commit_upd && (li_in == li_s1);
			fwd_hdata_s1 <= hist_new;
			fwd_g_s1     <= commit_upd && (gi_in == gi_s1);
			fwd_gdata_s1 <= gctr_new;
		end
		if (state_q == ST_S1) begin
			lh_s2 <= lh_cur;
		end
		if (commit_pred) begin
			out_data_q.predict_taken <= pred;
			out_data_q.used_local    <= choose_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------- checks ----------------
	`LGBP_ASSERT_NOW(a_no_accept_in_clear, clk, arst_n, state_q == ST_CLR, !in_ready)
	`LGBP_ASSERT_NEXT(a_accept_to_s1, clk, arst_n, in_valid && in_ready, state_q == ST_S1)
	`LGBP_ASSERT_NEXT(a_s1_to_s2, clk, arst_n, state_q == ST_S1, state_q == ST_S2)
	`LGBP_ASSERT_NOW(a_out_from_predict, clk, arst_n, $rose(out_valid),
		$past(state_q == ST_S2 && cmd_s1 == CMD_PREDICT))

endmodule
